// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker files of this project.
// Every macro samples on the rising clock edge and is switched off while reset is applied.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("checker: property violated");

// If the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker: property violated");

`endif

// ----- rtl/core/ibe_pkg.sv -----
// ----------------------------------------------------------------------------
// ibe_pkg
// Shared types, constants and command/status structures of the infix boolean
// evaluator.
// ----------------------------------------------------------------------------
package ibe_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int NUM_VARS    = 26;
    localparam int NUM_LETTERS = 26;

    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int STK_CW = $clog2(STACK_DEPTH + 1);

    typedef logic [STK_AW-1:0]      stk_addr_t;
    typedef logic [STK_CW-1:0]      stk_cnt_t;
    typedef logic [1:0]             mode_t;
    typedef logic [4:0]             var_idx_t;
    typedef logic [2:0]             op_t;
    typedef logic [NUM_LETTERS-1:0] letters_t;

    localparam stk_cnt_t STK_FULL = STK_CW'(STACK_DEPTH);

    // Token kinds.
    localparam mode_t MODE_VAR    = 2'd0;
    localparam mode_t MODE_LPAREN = 2'd1;
    localparam mode_t MODE_RPAREN = 2'd2;
    localparam mode_t MODE_OP     = 2'd3;

    // Operator codes, in rising precedence; the paren marker lives only on the stack.
    localparam op_t OP_EQV   = 3'd0;
    localparam op_t OP_IMP   = 3'd1;
    localparam op_t OP_OR    = 3'd2;
    localparam op_t OP_AND   = 3'd3;
    localparam op_t OP_NOT   = 3'd4;
    localparam op_t OP_PAREN = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_tok;
        logic push_var;
        logic push_paren;
        logic push_tok_op;
        logic pop_op;
        logic reload_op;
        logic apply_r;
        logic apply_l;
        logic set_err;
        logic finish;
    } ibe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        op_t   op_code;
        logic  last;
        logic  op_empty;
        op_t   top_op;
        logic  cur_unary;
        logic  out_busy;
    } ibe_status_t;

endpackage

// ----- rtl/core/ibe_ifs.sv -----
// ----------------------------------------------------------------------------
// ibe_ifs
// Channel interfaces of the infix boolean evaluator: tokens, results and the
// letter value configuration write.
// ----------------------------------------------------------------------------
interface ibe_token_if;
    import ibe_pkg::*;

    logic     valid;
    logic     ready;
    mode_t    mode;
    var_idx_t var_index;
    op_t      op_code;
    logic     last_token;

    modport source (output valid, output mode, output var_index, output op_code,
                    output last_token, input ready);
    modport sink   (input valid, input mode, input var_index, input op_code,
                    input last_token, output ready);
endinterface

interface ibe_result_if;
    logic valid;
    logic ready;
    logic truth;
    logic error;

    modport source (output valid, output truth, output error, input ready);
    modport sink   (input valid, input truth, input error, output ready);
endinterface

interface ibe_cfg_if;
    import ibe_pkg::*;

    logic     valid;
    logic     ready;
    letters_t letter_values;

    modport source (output valid, output letter_values, input ready);
    modport sink   (input valid, input letter_values, output ready);
endinterface

// ----- rtl/core/ibe_datapath.sv -----
// ----------------------------------------------------------------------------
// ibe_datapath
// Operator and value stacks with cached top entries, operand registers, the
// letter value register and the result register.
// ----------------------------------------------------------------------------
module ibe_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ibe_pkg::ibe_cmd_t    cmd,
    output ibe_pkg::ibe_status_t status,
    input  ibe_pkg::mode_t      tok_mode,
    input  ibe_pkg::var_idx_t   tok_var_index,
    input  ibe_pkg::op_t        tok_op_code,
    input  logic                tok_last_token,
    input  logic                cfg_valid,
    input  ibe_pkg::letters_t   cfg_letter_values,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_truth,
    output logic                out_error
);
    import ibe_pkg::*;

    // Stack storage.
    op_t  omem [STACK_DEPTH];
    logic vmem [STACK_DEPTH];

    // Control state.
    stk_cnt_t op_top_reg,  op_top_next;
    stk_cnt_t val_top_reg, val_top_next;
    logic     err_reg,       err_next;
    logic     out_valid_reg, out_valid_next;
    letters_t letter_values_reg;

    // Payload.
    mode_t    mode_reg;
    var_idx_t var_reg;
    op_t      op_code_reg;
    logic     last_reg;
    op_t      top_op_reg, top_op_next;
    logic     tos_reg,    tos_next;
    op_t      cur_op_reg, cur_op_next;
    logic     r_reg,      r_next;
    op_t      op_rd_reg;
    logic     val_rd_reg;
    logic     out_truth_reg, out_truth_next;
    logic     out_error_reg, out_error_next;

    // Memory ports.
    logic      owr_en, vwr_en;
    stk_addr_t owr_addr, vwr_addr;
    op_t       owr_data;
    logic      vwr_data;
    stk_cnt_t  op_rd_cnt, val_rd_cnt, val_top_m1;

    logic val_empty, val_full, op_empty, op_full;
    logic var_bit, r_val, l_val, res_val;
    op_t  op_in;

    assign val_empty  = (val_top_reg == '0);
    assign val_full   = (val_top_reg == STK_FULL);
    assign op_empty   = (op_top_reg == '0);
    assign op_full    = (op_top_reg == STK_FULL);
    assign val_top_m1 = val_top_reg - STK_CW'(1);
    // The entry below the top is always fetched, so it is ready in the cycle after a pop.
    assign op_rd_cnt  = op_top_reg - STK_CW'(2);
    assign val_rd_cnt = val_top_reg - STK_CW'(2);

    always_comb
    begin
        var_bit = 1'b0;
        if (int'(var_reg) < NUM_VARS)
        begin
            var_bit = letter_values_reg[var_reg];
        end
    end

    always_comb
    begin
        op_top_next    = op_top_reg;
        val_top_next   = val_top_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_truth_next = out_truth_reg;
        out_error_next = out_error_reg;
        top_op_next    = top_op_reg;
        tos_next       = tos_reg;
        cur_op_next    = cur_op_reg;
        r_next         = r_reg;
        owr_en         = 1'b0;
        owr_addr       = op_top_reg[STK_AW-1:0];
        op_in          = cmd.push_paren ? OP_PAREN : op_code_reg;
        owr_data       = op_in;
        vwr_en         = 1'b0;
        vwr_addr       = val_empty ? '0 : val_top_m1[STK_AW-1:0];
        vwr_data       = 1'b0;
        r_val          = val_empty ? 1'b0 : tos_reg;
        l_val          = val_empty ? 1'b0 : val_rd_reg;
        res_val        = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.push_var)
        begin
            if (val_full)
            begin
                err_next = 1'b1;
            end
            else
            begin
                vwr_en       = 1'b1;
                vwr_addr     = val_top_reg[STK_AW-1:0];
                vwr_data     = var_bit;
                tos_next     = var_bit;
                val_top_next = val_top_reg + STK_CW'(1);
            end
        end

        if (cmd.push_paren || cmd.push_tok_op)
        begin
            if (op_full)
            begin
                err_next = 1'b1;
            end
            else
            begin
                owr_en      = 1'b1;
                top_op_next = op_in;
                op_top_next = op_top_reg + STK_CW'(1);
            end
        end

        if (cmd.pop_op)
        begin
            cur_op_next = top_op_reg;
            op_top_next = op_top_reg - STK_CW'(1);
        end

        if (cmd.reload_op)
        begin
            top_op_next = op_rd_reg;
        end

        // Right operand; a not is finished here, a binary operator waits for its left operand.
        if (cmd.apply_r)
        begin
            if (val_empty)
            begin
                err_next = 1'b1;
            end
            if (cur_op_reg == OP_NOT)
            begin
                res_val  = ~r_val;
                vwr_en   = 1'b1;
                vwr_data = res_val;
                tos_next = res_val;
                if (val_empty)
                begin
                    val_top_next = STK_CW'(1);
                end
            end
            else
            begin
                r_next = r_val;
                if (!val_empty)
                begin
                    val_top_next = val_top_m1;
                end
            end
        end

        if (cmd.apply_l)
        begin
            if (val_empty)
            begin
                err_next     = 1'b1;
                val_top_next = STK_CW'(1);
            end
            case (cur_op_reg)
                OP_EQV:  res_val = ~(l_val ^ r_reg);
                OP_IMP:  res_val = ~l_val | r_reg;
                OP_OR:   res_val = l_val | r_reg;
                OP_AND:  res_val = l_val & r_reg;
                default: res_val = ~r_reg;
            endcase
            vwr_en   = 1'b1;
            vwr_data = res_val;
            tos_next = res_val;
        end

        if (cmd.set_err)
        begin
            err_next = 1'b1;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_truth_next = val_empty ? 1'b0 : tos_reg;
            out_error_next = err_reg | val_empty;
            op_top_next    = '0;
            val_top_next   = '0;
            err_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_top_reg        <= '0;
            val_top_reg       <= '0;
            err_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
            letter_values_reg <= '0;
        end
        else
        begin
            op_top_reg    <= op_top_next;
            val_top_reg   <= val_top_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                letter_values_reg <= cfg_letter_values;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tok)
        begin
            mode_reg    <= tok_mode;
            var_reg     <= tok_var_index;
            op_code_reg <= tok_op_code;
            last_reg    <= tok_last_token;
        end
        top_op_reg    <= top_op_next;
        tos_reg       <= tos_next;
        cur_op_reg    <= cur_op_next;
        r_reg         <= r_next;
        out_truth_reg <= out_truth_next;
        out_error_reg <= out_error_next;
    end

    always_ff @(posedge clk)
    begin
        op_rd_reg  <= omem[op_rd_cnt[STK_AW-1:0]];
        val_rd_reg <= vmem[val_rd_cnt[STK_AW-1:0]];
        if (owr_en)
        begin
            omem[owr_addr] <= owr_data;
        end
        if (vwr_en)
        begin
            vmem[vwr_addr] <= vwr_data;
        end
    end

    assign status.mode      = mode_reg;
    assign status.op_code   = op_code_reg;
    assign status.last      = last_reg;
    assign status.op_empty  = op_empty;
    assign status.top_op    = top_op_reg;
    assign status.cur_unary = (cur_op_reg == OP_NOT);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_truth = out_truth_reg;
    assign out_error = out_error_reg;

endmodule

// ----- rtl/core/ibe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ibe_ctrl
// Sequencer of the evaluator: decodes each token and steps the datapath
// through operator pops, operator application and the final flush.
// ----------------------------------------------------------------------------
module ibe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tok_valid,
    output logic                 tok_ready,
    input  ibe_pkg::ibe_status_t status,
    output ibe_pkg::ibe_cmd_t    cmd
);
    import ibe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TAKE,
        S_CLOSE,
        S_FLUSH,
        S_APPLY1,
        S_APPLY2,
        S_RELOAD,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg,   ret_next;
    state_t after_tok;

    // Where a token goes once its own work is done.
    assign after_tok = status.last ? S_FLUSH : S_IDLE;
    assign tok_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (tok_valid)
                begin
                    cmd.load_tok = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.mode)
                    MODE_VAR:
                    begin
                        cmd.push_var = 1'b1;
                        state_next   = after_tok;
                    end
                    MODE_LPAREN:
                    begin
                        cmd.push_paren = 1'b1;
                        state_next     = after_tok;
                    end
                    MODE_RPAREN:
                    begin
                        state_next = S_CLOSE;
                    end
                    default:
                    begin
                        if (status.op_code == OP_NOT)
                        begin
                            cmd.push_tok_op = 1'b1;
                            state_next      = after_tok;
                        end
                        else if (status.op_code > OP_NOT)
                        begin
                            state_next = after_tok;
                        end
                        else
                        begin
                            state_next = S_TAKE;
                        end
                    end
                endcase
            end
            S_TAKE:
            begin
                if (!status.op_empty && status.top_op != OP_PAREN &&
                    status.top_op >= status.op_code)
                begin
                    cmd.pop_op = 1'b1;
                    ret_next   = S_TAKE;
                    state_next = S_APPLY1;
                end
                else
                begin
                    cmd.push_tok_op = 1'b1;
                    state_next      = after_tok;
                end
            end
            S_CLOSE:
            begin
                if (status.op_empty)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = after_tok;
                end
                else
                begin
                    cmd.pop_op = 1'b1;
                    if (status.top_op == OP_PAREN)
                    begin
                        ret_next   = after_tok;
                        state_next = S_RELOAD;
                    end
                    else
                    begin
                        ret_next   = S_CLOSE;
                        state_next = S_APPLY1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (status.op_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.pop_op = 1'b1;
                    ret_next   = S_FLUSH;
                    if (status.top_op == OP_PAREN)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = S_RELOAD;
                    end
                    else
                    begin
                        state_next = S_APPLY1;
                    end
                end
            end
            S_APPLY1:
            begin
                cmd.reload_op = 1'b1;
                cmd.apply_r   = 1'b1;
                state_next    = status.cur_unary ? ret_reg : S_APPLY2;
            end
            S_APPLY2:
            begin
                cmd.apply_l = 1'b1;
                state_next  = ret_reg;
            end
            S_RELOAD:
            begin
                cmd.reload_op = 1'b1;
                state_next    = ret_reg;
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule

// ----- rtl/core/infix_boolean_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// infix_boolean_evaluator_top
// Evaluates an infix boolean expression, token by token, under a configured
// assignment of truth values to the letters A to Z.
// ----------------------------------------------------------------------------
// Usage. Tokens arrive on the tok channel, one transaction per token: a
// variable, a left or right parenthesis, or an operator (equivalence,
// implication, or, and, not). The token flagged last_token closes the
// expression; only it produces a transaction on the res channel, carrying the
// truth value and an error flag for overflow, underflow or unmatched
// parentheses. The cfg channel writes the letter values and is always ready;
// write it only while no expression is in flight.
// Timing. The sequencer steps one stack operation at a time, and a new token
// is taken only once it is back in idle. Each token is loaded and decoded; a
// binary operator then pops every stacked operator of equal or higher
// precedence, and a right parenthesis pops down to its left parenthesis. Each
// popped operator is applied, its right operand first and, for a binary one,
// its left operand after. The last token adds the flush, which applies every
// stacked operator and flags each left parenthesis still open; the result is
// registered once the result register is free. The stack memories are read
// through registers, and the cached top is reloaded after each pop.
// Reset clears the stacks, the error flag, the result valid flag and the
// letter values. A stalled receiver holds the result in its register while
// the next expression is taken in; only the following result waits for it.
// ----------------------------------------------------------------------------
module infix_boolean_evaluator_top (
    input  logic         clk,
    input  logic         rst_n,
    ibe_token_if.sink    tok,
    ibe_result_if.source res,
    ibe_cfg_if.sink      cfg
);
    import ibe_pkg::*;

    ibe_cmd_t    cmd;
    ibe_status_t status;

    // The letter register takes a write in any cycle.
    assign cfg.ready = 1'b1;

    // The sequencer owns the token handshake and drives the datapath by commands.
    ibe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok.valid),
        .tok_ready (tok.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds both stacks and the result register that feeds res.
    ibe_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .tok_mode          (tok.mode),
        .tok_var_index     (tok.var_index),
        .tok_op_code       (tok.op_code),
        .tok_last_token    (tok.last_token),
        .cfg_valid         (cfg.valid),
        .cfg_letter_values (cfg.letter_values),
        .out_valid         (res.valid),
        .out_ready         (res.ready),
        .out_truth         (res.truth),
        .out_error         (res.error)
    );

endmodule

// ----- rtl/core/ibe_checker.sv -----
// ----------------------------------------------------------------------------
// ibe_checker
// Port-level checks of the evaluator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibe_checker (
    input logic clk,
    input logic rst_n,
    input logic tok_valid,
    input logic tok_ready,
    input logic res_valid,
    input logic res_ready,
    input logic res_truth,
    input logic res_error,
    input logic cfg_ready
);

    // A stalled result keeps its contents.
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_truth) && $stable(res_error))

    // Each token is decoded before the next one is taken.
    `ASSERT_NEXT(a_tok_one_at_a_time, clk, rst_n, tok_valid && tok_ready, !tok_ready)

    // No result can appear in the cycle after a token is taken.
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, tok_valid && tok_ready && !res_valid, !res_valid)

    // The letter register accepts a write at any time.
    `ASSERT_ALWAYS(a_cfg_always_ready, clk, rst_n, cfg_ready)

endmodule

bind infix_boolean_evaluator_top ibe_checker u_ibe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (tok.valid),
    .tok_ready (tok.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_truth (res.truth),
    .res_error (res.error),
    .cfg_ready (cfg.ready)
);

// ----- test/infix_boolean_evaluator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_boolean_evaluator_top_tb
// Self-checking testbench of the infix boolean evaluator. A queue of pending
// tokens feeds a clocked driver. Every accepted token goes through a
// behavioural copy of the evaluator that predicts the result of each
// expression. A clocked monitor compares every result transaction, field by
// field, with the oldest prediction. Directed expressions come first, then
// random well-formed, noisy, broken and overflowing expressions under several
// letter assignments and idling patterns.
// ----------------------------------------------------------------------------
module infix_boolean_evaluator_top_tb;
    import ibe_pkg::*;

    // Input operator codes that the evaluator must ignore.
    localparam op_t OP_FIRST_VOID = 3'd5;
    localparam op_t OP_LAST_VOID  = 3'd7;

    localparam int unsigned LONG_HOLD   = 400;       // cycles of the long receiver hold-off
    localparam int unsigned DRAIN_TAIL  = 40;        // quiet cycles after the last result
    localparam int unsigned PHASE_ITEMS = 190;       // random tokens per idling phase
    localparam int unsigned PRESS_EXPRS = 30;        // short expressions under pressure
    localparam longint      TIMEOUT_NS  = 5_000_000; // watchdog time-out

    typedef struct packed {
        mode_t    mode;
        var_idx_t var_index;
        op_t      op_code;
        logic     last_token;
    } token_t;

    typedef struct packed {
        logic truth;
        logic error;
    } outcome_t;

    logic clk;
    logic rst_n;

    ibe_token_if  tok_ch ();
    ibe_result_if res_ch ();
    ibe_cfg_if    cfg_ch ();

    infix_boolean_evaluator_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Tokens waiting to be offered, the expression under construction, and
    // the predicted result of every expression whose last token was taken.
    token_t   token_backlog [$];
    token_t   phrase [$];
    outcome_t expected_outcomes [$];

    // Idling controls; the sequence changes the idling rates only between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        pressure_go = 1'b0;
    logic        hold_active;

    int unsigned mismatch_count = 0;

    // Shadow copy of the evaluator state and of the letter assignment.
    op_t                    op_shadow [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] val_shadow;
    int unsigned            op_depth = 0;
    int unsigned            val_depth = 0;
    logic                   fault_seen = 1'b0;
    letters_t               letters_model = '0;

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Expression evaluator shadow. The stacks behave as in the block: a push
    // onto a full stack is dropped, a pop from an empty value stack reads 0,
    // and both of these mark the expression as faulty.
    // ------------------------------------------------------------------------
    function automatic void stack_value(logic bit_value);
        if (val_depth >= STACK_DEPTH)
        begin
            fault_seen = 1'b1;
            return;
        end
        val_shadow[val_depth] = bit_value;
        val_depth++;
    endfunction

    function automatic logic unstack_value();
        if (val_depth == 0)
        begin
            fault_seen = 1'b1;
            return 1'b0;
        end
        val_depth--;
        return val_shadow[val_depth];
    endfunction

    function automatic void stack_op(op_t code);
        if (op_depth >= STACK_DEPTH)
        begin
            fault_seen = 1'b1;
            return;
        end
        op_shadow[op_depth] = code;
        op_depth++;
    endfunction

    function automatic void reduce_operator(op_t code);
        logic rhs;
        logic lhs;
        logic outcome_bit;
        rhs = unstack_value();
        lhs = 1'b0;
        if (code != OP_NOT)
            lhs = unstack_value();
        case (code)
            OP_EQV:  outcome_bit = (lhs == rhs);
            OP_IMP:  outcome_bit = ~lhs | rhs;
            OP_OR:   outcome_bit = lhs | rhs;
            OP_AND:  outcome_bit = lhs & rhs;
            default: outcome_bit = ~rhs;
        endcase
        stack_value(outcome_bit);
    endfunction

    // Folds one accepted token into the shadow state; the last token of an
    // expression flushes the stacks and queues the predicted result.
    function automatic void evaluate_token(token_t t);
        op_t      top;
        logic     matched;
        outcome_t prediction;
        case (t.mode)
            MODE_VAR:
                stack_value((t.var_index < NUM_VARS) ? letters_model[t.var_index] : 1'b0);
            MODE_LPAREN:
                stack_op(OP_PAREN);
            MODE_RPAREN:
            begin
                // Unwind to the matching left parenthesis; without one, every
                // stacked operator is applied and the expression is faulty.
                matched = 1'b0;
                while (op_depth > 0 && !matched)
                begin
                    op_depth--;
                    top = op_shadow[op_depth];
                    if (top == OP_PAREN)
                        matched = 1'b1;
                    else
                        reduce_operator(top);
                end
                if (!matched)
                    fault_seen = 1'b1;
            end
            default:
            begin
                if (t.op_code <= OP_NOT)
                begin
                    // Binary operators pop everything of equal or higher
                    // precedence down to a parenthesis; not pops nothing.
                    if (t.op_code != OP_NOT)
                    begin
                        while (op_depth > 0 && op_shadow[op_depth-1] != OP_PAREN &&
                               op_shadow[op_depth-1] >= t.op_code)
                        begin
                            top = op_shadow[op_depth-1];
                            op_depth--;
                            reduce_operator(top);
                        end
                    end
                    stack_op(t.op_code);
                end
            end
        endcase

        if (t.last_token)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                top = op_shadow[op_depth];
                if (top == OP_PAREN)
                    fault_seen = 1'b1;
                else
                    reduce_operator(top);
            end
            prediction.truth = 1'b0;
            if (val_depth > 0)
                prediction.truth = val_shadow[val_depth-1];
            else
                fault_seen = 1'b1;
            prediction.error = fault_seen;
            expected_outcomes.push_back(prediction);
            op_depth = 0;
            val_depth = 0;
            fault_seen = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Expression construction. Unused fields of a token always carry random
    // values, so that the block is seen to ignore them.
    // ------------------------------------------------------------------------
    function automatic void emit_var(var_idx_t idx);
        token_t t;
        t.mode       = MODE_VAR;
        t.var_index  = idx;
        t.op_code    = op_t'($urandom_range(OP_LAST_VOID));
        t.last_token = 1'b0;
        phrase.push_back(t);
    endfunction

    function automatic void emit_op(op_t code);
        token_t t;
        t.mode       = MODE_OP;
        t.var_index  = var_idx_t'($urandom_range(31));
        t.op_code    = code;
        t.last_token = 1'b0;
        phrase.push_back(t);
    endfunction

    function automatic void emit_sym(mode_t kind);
        token_t t;
        t.mode       = kind;
        t.var_index  = var_idx_t'($urandom_range(31));
        t.op_code    = op_t'($urandom_range(OP_LAST_VOID));
        t.last_token = 1'b0;
        phrase.push_back(t);
    endfunction

    // Mostly real letters; now and then an index past Z, which reads as 0.
    function automatic var_idx_t pick_letter();
        if ($urandom_range(15) == 0)
            return var_idx_t'($urandom_range(31, NUM_VARS));
        return var_idx_t'($urandom_range(NUM_VARS - 1));
    endfunction

    function automatic void grow_operand(int unsigned depth);
        int unsigned pick;
        pick = (depth == 0) ? 0 : $urandom_range(5);
        case (pick)
            0, 1, 2: emit_var(pick_letter());
            3:
            begin
                emit_op(OP_NOT);
                grow_operand(depth - 1);
            end
            default:
            begin
                emit_sym(MODE_LPAREN);
                grow_expression(depth - 1);
                emit_sym(MODE_RPAREN);
            end
        endcase
    endfunction

    function automatic void grow_expression(int unsigned depth);
        int unsigned terms;
        terms = $urandom_range(3);
        grow_operand(depth);
        repeat (terms)
        begin
            emit_op(op_t'($urandom_range(OP_AND)));
            grow_operand(depth);
        end
    endfunction

    // Flags the final token of the phrase as last and hands the phrase over
    // to the driver; returns the number of tokens.
    function automatic int unsigned seal();
        token_t      t;
        int unsigned n;
        n = phrase.size();
        t = phrase.pop_back();
        t.last_token = 1'b1;
        phrase.push_back(t);
        foreach (phrase[i])
            token_backlog.push_back(phrase[i]);
        phrase.delete();
        return n;
    endfunction

    // Builds one random expression: mostly well formed, some with ignored
    // operator codes scattered in, some random token soup and a few that
    // overrun one of the stacks.
    function automatic int unsigned compose_sentence(int unsigned depth_cap);
        int unsigned kind;
        int unsigned n;
        token_t      junk;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            grow_expression($urandom_range(depth_cap));
            if (kind >= 68)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    junk.mode       = MODE_OP;
                    junk.var_index  = var_idx_t'($urandom_range(31));
                    junk.op_code    = op_t'($urandom_range(OP_LAST_VOID, OP_FIRST_VOID));
                    junk.last_token = 1'b0;
                    phrase.insert($urandom_range(phrase.size()), junk);
                end
            end
        end
        else if (kind < 95)
        begin
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                junk.mode       = mode_t'($urandom_range(3));
                junk.var_index  = var_idx_t'($urandom_range(31));
                junk.op_code    = op_t'($urandom_range(OP_LAST_VOID));
                junk.last_token = 1'b0;
                phrase.push_back(junk);
            end
        end
        else
        begin
            n = $urandom_range(STACK_DEPTH + 4, STACK_DEPTH + 1);
            case ($urandom_range(2))
                0: repeat (n) emit_var(pick_letter());
                1:
                begin
                    repeat (n) emit_sym(MODE_LPAREN);
                    emit_var(pick_letter());
                end
                default:
                begin
                    repeat (n) emit_op(OP_NOT);
                    emit_var(pick_letter());
                end
            endcase
        end
        return seal();
    endfunction

    // ------------------------------------------------------------------------
    // Token driver. A token stays on the channel until it is taken; only then
    // may the line go idle or the next token appear. The prediction is made
    // at the edge where the transaction completes.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_ch.valid      <= 1'b0;
            tok_ch.mode       <= MODE_VAR;
            tok_ch.var_index  <= '0;
            tok_ch.op_code    <= OP_EQV;
            tok_ch.last_token <= 1'b0;
        end
        else
        begin
            if (tok_ch.valid && tok_ch.ready)
            begin
                evaluate_token(token_backlog[0]);
                void'(token_backlog.pop_front());
            end
            if (!(tok_ch.valid && !tok_ch.ready))
            begin
                if (token_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    tok_ch.valid      <= 1'b1;
                    tok_ch.mode       <= token_backlog[0].mode;
                    tok_ch.var_index  <= token_backlog[0].var_index;
                    tok_ch.op_code    <= token_backlog[0].op_code;
                    tok_ch.last_token <= token_backlog[0].last_token;
                end
                else
                begin
                    tok_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Each result transaction is checked against the oldest
    // prediction; ready is dropped at random and during the long hold-off.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("unexpected result transaction: truth %0b, error %0b",
                           res_ch.truth, res_ch.error);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (res_ch.truth !== want.truth)
                    begin
                        $error("truth mismatch: expected %0b, actual %0b",
                               want.truth, res_ch.truth);
                        mismatch_count++;
                    end
                    if (res_ch.error !== want.error)
                    begin
                        $error("error mismatch: expected %0b, actual %0b",
                               want.error, res_ch.error);
                        mismatch_count++;
                    end
                end
            end
            res_ch.ready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The long hold-off of the receiver, counted here, lets the evaluator fill
    // its result register and stall the token channel while tokens keep coming.
    initial
    begin : long_hold
        hold_active = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Writes the letter assignment through the configuration channel, which is
    // only done while no expression is in flight.
    task automatic write_letters(input letters_t value);
        @(posedge clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.letter_values <= value;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
                break;
        end
        letters_model = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits until every token has been taken and every result has arrived,
    // then waits out the quiet tail set by DRAIN_TAIL.
    task automatic drain();
        while (token_backlog.size() != 0 || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : sequence_run
        int unsigned phase_items;
        int unsigned n;

        // The token and result channels take their idle values from the
        // driver and the monitor while reset is applied.
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.letter_values = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed expressions under an alternating assignment: the odd
        // letters are true.
        write_letters(26'h2AAAAAA);
        @(negedge clk);
        emit_var(var_idx_t'(0));
        n = seal();
        emit_var(var_idx_t'(NUM_VARS - 1));
        n = seal();
        emit_var(var_idx_t'(31));                           // index past Z
        n = seal();
        emit_var(var_idx_t'(1));
        emit_op(OP_EQV);
        emit_var(var_idx_t'(0));
        n = seal();
        emit_var(var_idx_t'(0));
        emit_op(OP_IMP);
        emit_var(var_idx_t'(1));
        n = seal();
        emit_op(OP_NOT);                                    // not (A or B) and B
        emit_sym(MODE_LPAREN);
        emit_var(var_idx_t'(0));
        emit_op(OP_OR);
        emit_var(var_idx_t'(1));
        emit_sym(MODE_RPAREN);
        emit_op(OP_AND);
        emit_var(var_idx_t'(1));
        n = seal();
        emit_var(var_idx_t'(1));                            // ignored code as last token
        emit_op(OP_LAST_VOID);
        n = seal();
        emit_var(var_idx_t'(1));                            // right paren with no partner
        emit_sym(MODE_RPAREN);
        n = seal();
        emit_sym(MODE_LPAREN);                              // left paren never closed
        emit_var(var_idx_t'(1));
        n = seal();
        emit_op(OP_AND);                                    // operands missing
        n = seal();
        emit_var(var_idx_t'(0));                            // surplus values
        emit_var(var_idx_t'(1));
        n = seal();
        drain();

        // Random phases, each under its own assignment and idling pattern:
        // none, sender idle, receiver stalling, then both at once.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_letters('1);
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                    write_letters('0);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                    write_letters(letters_t'($urandom()));
                end
                default:
                begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                    write_letters(letters_t'($urandom()));
                end
            endcase
            @(negedge clk);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                phase_items += compose_sentence(3);
            drain();
        end

        // Pressure: short expressions offered back to back while the receiver
        // holds off, so the evaluator backs up onto the token channel.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_letters(26'h1555555);
        @(negedge clk);
        repeat (PRESS_EXPRS)
            n = compose_sentence(1);
        pressure_go = 1'b1;
        drain();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // A hung handshake ends the run here.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
